// ===== design/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants of the huffman tree decoder
// Opcodes, controller states and the command/status structs that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package htd_pkg;

  // default size of the node store
  localparam int unsigned NodeCountDef = 512;

  // fixed field widths
  localparam int unsigned IdxW   = 9;
  localparam int unsigned TotalW = 31;
  localparam int unsigned SymW   = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned ByteBits = 8;

  // packed stream widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DECODE = 2'd1,
    OP_START  = 2'd2
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_ARRIVE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_node;
    logic start_run;
    logic begin_byte;
    logic step;
    logic corrupt;
    logic leaf;
    logic push;
    logic flush;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       stop;
    logic       present;
    logic       leaf;
    logic       pend_valid;
    logic       out_free;
  } status_t;

endpackage

// ===== design/huffman_tree_decoder.sv =====
// Load and start items take effect as they are accepted; a code byte is accepted,
//   then walked bit by bit, with an extra step on each leaf to fetch the root entry
//   and a final step to release its last result; output stalls lengthen this.
// Rate is set by the dependent node store read of each bit's child.
// Reset clears walk state, counters, configuration and output valid; the node
//   store is not cleared and holds nothing defined until loaded.
// ----------------------------------------------------------------------------
// huffman_tree_decoder: huffman decoder walking a stored code tree
// Stream in load/start/decode items, stream out decoded symbols with corrupt
// and finished flags; APB port for root index and symbol total.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int unsigned NODE_COUNT = htd_pkg::NodeCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node_index, left_child, right_child, has_left, has_right, node_symbol,
  // code_byte, zero fill
  input  logic [htd_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // symbol
  output logic [htd_pkg::OutDataW-1:0]  m_axis_tdata,
  // corrupt, finished
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htd_pkg::PaddrW-1:0]    paddr,
  input  logic [htd_pkg::PdataW-1:0]    pwdata,
  output logic [htd_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  htd_pkg::cmd_t    cmd;
  htd_pkg::status_t stat;

  assign pready = 1'b1;

  htd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  htd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata)
  );

endmodule

// ===== design/htd_datapath.sv =====
// ----------------------------------------------------------------------------
// htd_datapath: node store, walk registers and result registers
// Holds the code tree, the current node, symbol count, halt flag, a pending
// result slot and the output register, plus the configuration registers.
// ----------------------------------------------------------------------------
module htd_datapath #(
  parameter int unsigned NODE_COUNT = htd_pkg::NodeCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  htd_pkg::cmd_t                 cmd_i,
  output htd_pkg::status_t              stat_o,
  input  logic [htd_pkg::InDataW-1:0]   s_tdata_i,
  input  logic [1:0]                    s_tuser_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [htd_pkg::OutDataW-1:0]  m_tdata_o,
  output logic [1:0]                    m_tuser_o,
  output logic                          m_tlast_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [htd_pkg::PaddrW-1:0]    paddr_i,
  input  logic [htd_pkg::PdataW-1:0]    pwdata_i,
  output logic [htd_pkg::PdataW-1:0]    prdata_o
);

  localparam int unsigned AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned HlPos = 2 * AW;
  localparam int unsigned HrPos = 2 * AW + 1;
  localparam int unsigned SyLo  = 2 * AW + 2;
  localparam int unsigned EW    = 2 * AW + 2 + htd_pkg::SymW;
  localparam int unsigned Recip = ((1 << 18) + NODE_COUNT - 1) / NODE_COUNT;

  // index reduced into the store: reciprocal multiply, exact for 9-bit input
  function automatic logic [AW-1:0] slot(input logic [htd_pkg::IdxW-1:0] x);
    logic [26:0] prod;
    logic [12:0] quo;
    logic [12:0] rem;
    prod = 27'(x) * 27'(Recip);
    quo  = 13'(prod >> 18);
    rem  = 13'(x) - 13'(quo * 13'(NODE_COUNT));
    if (NODE_COUNT >= 512) begin
      rem = 13'(x);
    end
    return rem[AW-1:0];
  endfunction

  // input fields
  logic [htd_pkg::IdxW-1:0] in_node, in_left, in_right;
  logic                     in_hl, in_hr;
  logic [htd_pkg::SymW-1:0] in_sym, in_code;
  assign in_node  = s_tdata_i[8:0];
  assign in_left  = s_tdata_i[17:9];
  assign in_right = s_tdata_i[26:18];
  assign in_hl    = s_tdata_i[27];
  assign in_hr    = s_tdata_i[28];
  assign in_sym   = s_tdata_i[36:29];
  assign in_code  = s_tdata_i[44:37];

  // configuration registers
  logic [htd_pkg::IdxW-1:0]   root_q;
  logic [htd_pkg::TotalW-1:0] total_q;
  logic                       cfg_wr;
  assign cfg_wr = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      total_q <= '0;
    end else if (cfg_wr) begin
      if (paddr_i[2]) begin
        total_q <= pwdata_i[htd_pkg::TotalW-1:0];
      end else begin
        root_q <= pwdata_i[htd_pkg::IdxW-1:0];
      end
    end
  end

  assign prdata_o = paddr_i[2] ? {1'b0, total_q} : {23'b0, root_q};

  // walk state
  logic [AW-1:0]               cur_node_q, cur_node_d;
  logic [htd_pkg::TotalW-1:0]  count_q, count_d;
  logic                        halted_q, halted_d;
  logic [htd_pkg::BitCntW-1:0] bits_left_q, bits_left_d;
  logic [htd_pkg::SymW-1:0]    byte_q, byte_d;
  logic [EW-1:0]               rdata_q;
  logic [AW-1:0]               raddr;
  logic                        rd_en;
  logic [AW-1:0]               root_slot;

  // node store
  logic [EW-1:0] node_mem [NODE_COUNT];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_node) begin
      node_mem[slot(in_node)] <= {in_sym, in_hr, in_hl, slot(in_right), slot(in_left)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= node_mem[raddr];
    end
  end

  // decode of the entry now in the read register
  logic          cur_bit, present, leaf;
  logic [AW-1:0] child;
  assign root_slot = slot(root_q);
  assign cur_bit   = byte_q[htd_pkg::ByteBits-1];
  assign present   = cur_bit ? rdata_q[HrPos] : rdata_q[HlPos];
  assign child     = cur_bit ? rdata_q[2*AW-1:AW] : rdata_q[AW-1:0];
  assign leaf      = !(rdata_q[HlPos] || rdata_q[HrPos]);

  // read address and walk updates
  always_comb begin
    rd_en       = 1'b0;
    raddr       = cur_node_q;
    cur_node_d  = cur_node_q;
    count_d     = count_q;
    halted_d    = halted_q;
    bits_left_d = bits_left_q;
    byte_d      = byte_q;
    if (cmd_i.start_run) begin
      cur_node_d = root_slot;
      count_d    = '0;
      halted_d   = 1'b0;
    end
    if (cmd_i.begin_byte) begin
      rd_en       = 1'b1;
      raddr       = cur_node_q;
      byte_d      = in_code;
      bits_left_d = htd_pkg::BitCntW'(htd_pkg::ByteBits);
    end
    if (cmd_i.step) begin
      rd_en       = 1'b1;
      raddr       = child;
      cur_node_d  = child;
      byte_d      = {byte_q[htd_pkg::ByteBits-2:0], 1'b0};
      bits_left_d = bits_left_q - 1'b1;
    end
    if (cmd_i.leaf) begin
      rd_en      = 1'b1;
      raddr      = root_slot;
      cur_node_d = root_slot;
      count_d    = count_q + 1'b1;
    end
    if (cmd_i.corrupt) begin
      halted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_node_q  <= '0;
      count_q     <= '0;
      halted_q    <= 1'b0;
      bits_left_q <= '0;
    end else begin
      cur_node_q  <= cur_node_d;
      count_q     <= count_d;
      halted_q    <= halted_d;
      bits_left_q <= bits_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // pending result: held until the walk knows whether it is the last one
  logic                     pend_valid_q, pend_valid_d;
  logic [htd_pkg::SymW-1:0] pend_sym_q, pend_sym_d;
  logic                     pend_cor_q, pend_cor_d;
  logic                     pend_fin_q, pend_fin_d;
  logic                     fin_now;
  assign fin_now = ({1'b0, count_q} + 32'd1) >= {1'b0, total_q};

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_cor_d   = pend_cor_q;
    pend_fin_d   = pend_fin_q;
    if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end
    if (cmd_i.corrupt) begin
      pend_valid_d = 1'b1;
      pend_sym_d   = '0;
      pend_cor_d   = 1'b1;
      pend_fin_d   = 1'b0;
    end
    if (cmd_i.leaf) begin
      pend_valid_d = 1'b1;
      pend_sym_d   = rdata_q[SyLo +: htd_pkg::SymW];
      pend_cor_d   = 1'b0;
      pend_fin_d   = fin_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    pend_cor_q <= pend_cor_d;
    pend_fin_q <= pend_fin_d;
  end

  // output register
  logic                     out_valid_q;
  logic [htd_pkg::SymW-1:0] out_sym_q;
  logic [1:0]               out_user_q;
  logic                     out_last_q;
  logic                     out_load;
  assign out_load = cmd_i.push || (cmd_i.flush && pend_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q  <= pend_sym_q;
      out_user_q <= {pend_fin_q, pend_cor_q};
      out_last_q <= cmd_i.flush;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_sym_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

  // status to controller
  assign stat_o.opcode     = s_tuser_i;
  assign stat_o.stop       = (bits_left_q == '0) || halted_q || !(count_q < total_q);
  assign stat_o.present    = present;
  assign stat_o.leaf       = leaf;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = !out_valid_q || m_tready_i;

endmodule

// ===== design/htd_controller.sv =====
// ----------------------------------------------------------------------------
// htd_controller: sequencer of the tree walk
// Takes items in idle, then steps one code bit per cycle through internal
// nodes and fetches the root entry in a step of its own on each leaf.
// ----------------------------------------------------------------------------
module htd_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  htd_pkg::status_t stat_i,
  output htd_pkg::cmd_t    cmd_o
);

  htd_pkg::state_e state_q, state_d;
  logic            slot_ok;

  // a new result may enter the pending slot once its old one can move out
  assign slot_ok = !stat_i.pend_valid || stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      htd_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          unique case (stat_i.opcode)
            htd_pkg::OP_LOAD:   cmd_o.load_node = 1'b1;
            htd_pkg::OP_START:  cmd_o.start_run = 1'b1;
            htd_pkg::OP_DECODE: begin
              cmd_o.begin_byte = 1'b1;
              state_d          = htd_pkg::S_EVAL;
            end
            default: ;
          endcase
        end
      end
      htd_pkg::S_EVAL, htd_pkg::S_ARRIVE: begin
        if (state_q == htd_pkg::S_ARRIVE && stat_i.leaf) begin
          // leaf reached: emit symbol, fetch root entry
          if (slot_ok) begin
            cmd_o.leaf = 1'b1;
            cmd_o.push = stat_i.pend_valid;
            state_d    = htd_pkg::S_EVAL;
          end
        end else if (stat_i.stop) begin
          // byte done, walk halted or total reached: release the held result as the last one
          if (slot_ok) begin
            cmd_o.flush = 1'b1;
            state_d     = htd_pkg::S_IDLE;
          end
        end else if (!stat_i.present) begin
          // missing child
          if (slot_ok) begin
            cmd_o.corrupt = 1'b1;
            cmd_o.push    = stat_i.pend_valid;
            state_d       = htd_pkg::S_EVAL;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = htd_pkg::S_ARRIVE;
        end
      end
      default: state_d = htd_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== design/htd_checker.sv =====
// ----------------------------------------------------------------------------
// htd_checker: port-level checks of the huffman tree decoder
// Result flag consistency and output stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module htd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [htd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser,
  input logic                         m_axis_tlast
);

  // a corrupt result carries no symbol and is never finished
  a_corrupt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("corrupt item with symbol or finished set");

  // a corrupt result ends the byte's results
  a_corrupt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("corrupt item not marked last");

  // reaching the total ends the byte's results
  a_finished_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("finished item not marked last");

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
